// ===== hdl/eiec_pkg.sv =====
`default_nettype none

package eiec_pkg;

  localparam int unsigned LINE_COUNT = 16;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned SEL_REGS   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IRQ_W      = 7;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 24;

  typedef logic [LINE_COUNT-1:0] word_t;
  typedef logic [IRQ_W-1:0]      irq_t;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_EN  = 3'd0,
    CFG_FALL_EN  = 3'd1,
    CFG_IRQ_MASK = 3'd2,
    CFG_SEL_0_3  = 3'd3,
    CFG_SEL_4_7  = 3'd4,
    CFG_SEL_8_11 = 3'd5,
    CFG_SEL_12_15 = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  // Port codes of a line selector; anything above PORT_D means port A
  typedef enum logic [SEL_W-1:0] {
    PORT_A = 4'd0,
    PORT_B = 4'd1,
    PORT_C = 4'd2,
    PORT_D = 4'd3
  } port_e;

  // Lines 0-4 map one to one, lines 5-9 and 10-15 are ORed into one output each
  function automatic irq_t irq_map(input word_t active);
    irq_t irq;
    irq[4:0] = active[4:0];
    irq[5]   = |active[9:5];
    irq[6]   = |active[15:10];
    return irq;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/eiec_edge.sv =====
`default_nettype none

module eiec_edge
  import eiec_pkg::*;
(
  input  wire logic  kind_i,
  input  wire word_t port_a_i,
  input  wire word_t port_b_i,
  input  wire word_t port_c_i,
  input  wire word_t port_d_i,
  input  wire word_t clear_bits_i,
  input  wire word_t sel_i [SEL_REGS],
  input  wire word_t rise_en_i,
  input  wire word_t fall_en_i,
  input  wire word_t prev_levels_i,
  input  wire word_t pending_i,
  input  wire logic  first_i,
  output word_t      levels_o,
  output word_t      pending_o
);

  word_t rise;
  word_t fall;

  // Route each line to its pin on the selected port
  for (genvar i = 0; i < LINE_COUNT; i++) begin : g_line
    localparam int unsigned Reg = i / SEL_REGS;
    localparam int unsigned Lsb = (i % SEL_REGS) * SEL_W;
    logic [SEL_W-1:0] code;

    assign code = sel_i[Reg][Lsb +: SEL_W];

    always_comb begin
      case (code)
        PORT_B:  levels_o[i] = port_b_i[i];
        PORT_C:  levels_o[i] = port_c_i[i];
        PORT_D:  levels_o[i] = port_d_i[i];
        default: levels_o[i] = port_a_i[i];
      endcase
    end
  end

  assign rise = levels_o & ~prev_levels_i & rise_en_i;
  assign fall = ~levels_o & prev_levels_i & fall_en_i;

  always_comb begin
    if (kind_i == KIND_CLEAR) begin
      pending_o = pending_i & ~clear_bits_i;
    end else if (first_i) begin
      pending_o = pending_i;
    end else begin
      pending_o = pending_i | rise | fall;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/external_interrupt_edge_controller.sv =====
// Sixteen-line external interrupt edge controller.
// Input channel s_axis: one beat is either a sample of the four 16-bit pin
// ports (tuser = 0) or a write-one-to-clear of pending bits (tuser = 1).
// Each line routes one pin from port A..D through its 4-bit selector, and an
// enabled rising or falling edge against the previous sample sets its
// pending bit, masked or not. The first sample after reset only records levels.
// Output channel m_axis: one beat per input beat carrying the pending bits
// after that beat and the seven interrupt outputs (pending AND mask, lines
// 0-4 alone, lines 5-9 and 10-15 grouped).
// The result of an accepted beat is held in the single output register.
// Throughput is one beat per cycle; the output register lets a new beat
// in whenever it is empty or being drained, so a stall on m_axis holds
// s_axis_tready_o low only while it lasts.
// Configuration writes on cfg_* are always taken; write only while idle.
// Reset clears the configuration registers, pending bits and levels and
// arms the first-sample flag; no output beat is valid out of reset.
`default_nettype none

module external_interrupt_edge_controller
  import eiec_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input beats
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // port_a_levels[15:0], port_b_levels[31:16], port_c_levels[47:32],
  // port_d_levels[63:48], clear_bits[79:64]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind[0]
  input  wire logic                  s_axis_tuser_i,
  // Result beats
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // pending_bits[15:0], interrupt_lines[22:16], zero[23]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // Configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [LINE_COUNT-1:0] cfg_data_i
);

  word_t rise_en_q;
  word_t fall_en_q;
  word_t mask_q;
  word_t sel_q [SEL_REGS];

  word_t prev_q;
  word_t pend_q;
  logic  first_q;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  word_t levels;
  word_t pend_d;
  logic  in_beat;
  logic  is_sample;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i & s_axis_tready_o;
  assign is_sample       = (s_axis_tuser_i == KIND_SAMPLE);

  // Configuration registers; indexes past the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_en_q <= '0;
      fall_en_q <= '0;
      mask_q    <= '0;
      for (int r = 0; r < SEL_REGS; r++) begin
        sel_q[r] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RISE_EN:   rise_en_q <= cfg_data_i;
        CFG_FALL_EN:   fall_en_q <= cfg_data_i;
        CFG_IRQ_MASK:  mask_q    <= cfg_data_i;
        CFG_SEL_0_3:   sel_q[0]  <= cfg_data_i;
        CFG_SEL_4_7:   sel_q[1]  <= cfg_data_i;
        CFG_SEL_8_11:  sel_q[2]  <= cfg_data_i;
        CFG_SEL_12_15: sel_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  eiec_edge u_edge (
    .kind_i        (s_axis_tuser_i),
    .port_a_i      (s_axis_tdata_i[15:0]),
    .port_b_i      (s_axis_tdata_i[31:16]),
    .port_c_i      (s_axis_tdata_i[47:32]),
    .port_d_i      (s_axis_tdata_i[63:48]),
    .clear_bits_i  (s_axis_tdata_i[79:64]),
    .sel_i         (sel_q),
    .rise_en_i     (rise_en_q),
    .fall_en_i     (fall_en_q),
    .prev_levels_i (prev_q),
    .pending_i     (pend_q),
    .first_i       (first_q),
    .levels_o      (levels),
    .pending_o     (pend_d)
  );

  // Line state: advance on every accepted beat, levels only on samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      pend_q  <= '0;
      first_q <= 1'b1;
    end else if (in_beat) begin
      pend_q <= pend_d;
      if (is_sample) begin
        prev_q  <= levels;
        first_q <= 1'b0;
      end
    end
  end

  // Output register: load on an accepted beat, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_data_q <= {1'b0, irq_map(pend_d & mask_q), pend_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire
